### design/kvmt_pkg.sv
// ============================================================================
// kvmt_pkg
// Shared types and codes for the key/value match table.
// ============================================================================
package kvmt_pkg;

    localparam int KEY_BITS        = 32;
    localparam int VALUE_BITS      = 32;
    localparam int COUNT_BITS      = 5;
    localparam int DEFAULT_ENTRIES = 16;

    // Operation codes
    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_UPSERT = 3'd1;
    localparam logic [2:0] FUNC_UPDATE = 3'd2;
    localparam logic [2:0] FUNC_REMOVE = 3'd3;
    localparam logic [2:0] FUNC_LOOKUP = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]            func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic [COUNT_BITS-1:0] entry_count;
    } rsp_item_t;

endpackage

### design/key_value_match_table_top.sv
// ============================================================================
// key_value_match_table_top
// Fully associative key/value table with insert, upsert, update, remove and
// lookup, one result per request.
// ============================================================================
// Each request transfer carries one operation that runs against the whole
// table; each produces exactly one response transfer with status, hit flag,
// lookup value and the number of used slots afterwards. Keys and values sit in
// two single-port-read synchronous memories (registered read data); the used
// flags are flip-flops cleared by reset, so the table is empty right after
// reset with no clearing pass. A request goes through an accept step that
// takes the transfer, a scan that reads one slot per cycle through the key
// memory port, and a write-back step that writes memory and loads the
// response register. The scan length is set by that one read port. The
// response register decouples the two sides: a new request is taken while
// the previous response still waits on rsp_stall; only the write-back step
// waits for the response register to free up.
// ============================================================================
module key_value_match_table_top #(
    parameter int ENTRIES = kvmt_pkg::DEFAULT_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  kvmt_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output kvmt_pkg::rsp_item_t rsp
);
    import kvmt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } state_t;

    // Control state (reset)
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;      // next slot address to read
    logic                cmp_vld_reg, cmp_vld_next;  // read data valid this cycle
    logic                found_reg, found_next;
    logic                free_found_reg, free_found_next;
    logic [ENTRIES-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;

    // Datapath registers (no reset)
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    req_item_t           req_reg, req_next;

    // Memories
    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;
    logic [IDX_W-1:0]      mem_raddr;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  key_we;
    logic                  val_we;

    // Write-back decision
    logic [1:0]            op_status;
    logic [VALUE_BITS-1:0] op_rd;
    logic                  op_new_slot;   // claim the lowest free slot
    logic                  op_val_only;   // overwrite value at the hit slot
    logic                  op_clr;        // free the hit slot
    logic                  out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // Key and value memories: one read and one write port each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[mem_waddr] <= req_reg.key;
        end
        key_rd_reg <= key_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[mem_waddr] <= req_reg.value;
        end
        val_rd_reg <= val_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Operation decode from the scan outcome
    // ------------------------------------------------------------------
    always_comb
    begin
        op_status   = ST_OK;
        op_rd       = '0;
        op_new_slot = 1'b0;
        op_val_only = 1'b0;
        op_clr      = 1'b0;
        case (req_reg.func)
            FUNC_INSERT, FUNC_UPSERT:
            begin
                if (found_reg)
                begin
                    if (req_reg.func == FUNC_INSERT)
                    begin
                        op_status = ST_DUP;
                    end
                    else
                    begin
                        op_val_only = 1'b1;
                    end
                end
                else if (free_found_reg)
                begin
                    op_new_slot = 1'b1;
                end
                else
                begin
                    op_status = ST_FULL;
                end
            end
            FUNC_UPDATE:
            begin
                if (found_reg)
                begin
                    op_val_only = 1'b1;
                end
                else
                begin
                    op_status = ST_NOTFOUND;
                end
            end
            FUNC_REMOVE:
            begin
                if (found_reg)
                begin
                    op_clr = 1'b1;
                end
                else
                begin
                    op_status = ST_NOTFOUND;
                end
            end
            FUNC_LOOKUP:
            begin
                if (found_reg)
                begin
                    op_rd = hit_val_reg;
                end
                else
                begin
                    op_status = ST_NOTFOUND;
                end
            end
            default:
            begin
                // unused codes: no operation
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: accept, scan, write back
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_idx_next   = free_idx_reg;
        req_next        = req_reg;
        mem_raddr       = issue_reg[IDX_W-1:0];
        mem_waddr       = hit_idx_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    issue_next      = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue side
                if (issue_reg < ENTRIES_CNT)
                begin
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                // compare side, working on the slot issued in the previous cycle
                if (cmp_vld_reg)
                begin
                    if (used_reg[cmp_idx_reg] && (key_rd_reg == req_reg.key) && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_val_next = val_rd_reg;
                    end
                    if (!used_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    key_we    = op_new_slot;
                    val_we    = op_new_slot || op_val_only;
                    mem_waddr = op_new_slot ? free_idx_reg : hit_idx_reg;
                    if (op_new_slot)
                    begin
                        used_next[free_idx_reg] = 1'b1;
                        count_next              = count_reg + 1'b1;
                    end
                    if (op_clr)
                    begin
                        used_next[hit_idx_reg] = 1'b0;
                        count_next             = count_reg - 1'b1;
                    end
                    rsp_next.status      = op_status;
                    rsp_next.hit         = found_reg;
                    rsp_next.read_value  = op_rd;
                    rsp_next.entry_count = COUNT_BITS'(count_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            used_reg       <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        req_reg      <= req_next;
    end

`ifndef NO_ASSERTIONS
    // Entry counter tracks the used flags
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(used_reg)))
        else $error("entry count out of step with used flags");

    // A recorded hit always points at a used slot
    a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) && found_reg |-> used_reg[hit_idx_reg])
        else $error("hit index points at a free slot");

    // A recorded free slot is really free
    a_free_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) && free_found_reg |-> !used_reg[free_idx_reg])
        else $error("free index points at a used slot");

    // Write-back only after a complete scan
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_WRITE) |-> issue_reg == ENTRIES_CNT)
        else $error("write-back entered before scan finished");

    // A new response only comes out of the write-back step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_WRITE)
        else $error("response raised outside write-back");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: key/value match table testbench
// Drives insert, upsert, update, remove and lookup transfers into the table and
// checks every response against a local model of the slot array. Runs a
// directed opening, then random traffic in fill, balanced and drain mixes,
// under three idle patterns and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import kvmt_pkg::*;

    localparam int TABLE_SLOTS    = DEFAULT_ENTRIES;
    localparam int POOL_KEYS      = 24;   // more keys than slots, so the table fills
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer on either side
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;   // idle margin after the last response
    localparam int MIX_BLOCK      = 48;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the slot array, computes the response
    // each accepted request should give and compares responses in order.
    // ------------------------------------------------------------------------
    class kv_table_scoreboard;
        bit                    in_use[TABLE_SLOTS];
        logic [KEY_BITS-1:0]   stored_key[TABLE_SLOTS];
        logic [VALUE_BITS-1:0] stored_value[TABLE_SLOTS];
        rsp_item_t             pending_rsp[$];
        int                    errors;
        int                    printed;

        function new();
            errors  = 0;
            printed = 0;
            foreach (in_use[i])
                in_use[i] = 1'b0;
        endfunction

        // Apply one request to the local table and queue its response.
        function void predict_request(req_item_t item);
            int        match_idx;
            int        free_idx;
            int        used_cnt;
            rsp_item_t want;

            match_idx = -1;
            free_idx  = -1;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (in_use[i] && stored_key[i] == item.key && match_idx < 0)
                    match_idx = i;
                if (!in_use[i] && free_idx < 0)
                    free_idx = i;
            end

            want.status     = ST_OK;
            want.hit        = (match_idx >= 0);
            want.read_value = '0;

            case (item.func)
                FUNC_INSERT, FUNC_UPSERT:
                begin
                    if (match_idx >= 0)
                    begin
                        if (item.func == FUNC_INSERT)
                            want.status = ST_DUP;
                        else
                            stored_value[match_idx] = item.value;
                    end
                    else if (free_idx < 0)
                        want.status = ST_FULL;
                    else
                    begin
                        in_use[free_idx]       = 1'b1;
                        stored_key[free_idx]   = item.key;
                        stored_value[free_idx] = item.value;
                    end
                end
                FUNC_UPDATE:
                begin
                    if (match_idx >= 0)
                        stored_value[match_idx] = item.value;
                    else
                        want.status = ST_NOTFOUND;
                end
                FUNC_REMOVE:
                begin
                    if (match_idx >= 0)
                        in_use[match_idx] = 1'b0;
                    else
                        want.status = ST_NOTFOUND;
                end
                FUNC_LOOKUP:
                begin
                    if (match_idx >= 0)
                        want.read_value = stored_value[match_idx];
                    else
                        want.status = ST_NOTFOUND;
                end
                default: ; // unused codes leave the table alone
            endcase

            used_cnt = 0;
            foreach (in_use[i])
                used_cnt += in_use[i];
            want.entry_count = used_cnt[COUNT_BITS-1:0];
            pending_rsp.push_back(want);
        endfunction

        // Prints are capped so a broken design cannot flood the log; every
        // mismatch is still counted.
        task report_mismatch(string msg);
            errors++;
            if (printed < 100)
            begin
                printed++;
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        task check_response(rsp_item_t got);
            rsp_item_t want;

            if (pending_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response with nothing outstanding: %p", got));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value got %08h want %08h",
                                          got.read_value, want.read_value));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count got %0d want %0d",
                                          got.entry_count, want.entry_count));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_value_match_table_top #(
        .ENTRIES (TABLE_SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    kv_table_scoreboard    sb;
    int                    send_idle_pct;
    int                    rsp_idle_pct;
    int                    rsp_holdoff;  // set by the stimulus, counted down by the receiver
    logic [KEY_BITS-1:0]   key_pool[POOL_KEYS];

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Idle cycles carry random payload with valid low; the DUT must ignore it.
    task automatic send_request(input req_item_t item);
        req_item_t junk;

        while ($urandom_range(99) < send_idle_pct)
        begin
            junk.func  = 3'($urandom_range(7));
            junk.key   = $urandom;
            junk.value = $urandom;
            req_valid <= 1'b0;
            req       <= junk;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        // values read here are the ones the DUT saw at this edge
        while (req_stall)
            @(posedge clk);
        sb.predict_request(item);
    endtask

    task automatic send_op(input logic [2:0] func, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] value);
        req_item_t item;

        item.func  = func;
        item.key   = key;
        item.value = value;
        send_request(item);
    endtask

    // Random request shaped by the current mix. Keys mostly come from a small
    // pool so that hits, duplicates and a full table happen often.
    function automatic req_item_t make_request(traffic_mix_t mix);
        req_item_t item;
        int        roll;
        int        w_ins;
        int        w_ups;
        int        w_upd;
        int        w_rem;
        int        w_look;

        case (mix)
            MIX_FILL:  begin w_ins = 55; w_ups = 15; w_upd = 8;  w_rem = 7;  w_look = 12; end
            MIX_DRAIN: begin w_ins = 15; w_ups = 10; w_upd = 10; w_rem = 45; w_look = 17; end
            default:   begin w_ins = 25; w_ups = 15; w_upd = 15; w_rem = 20; w_look = 22; end
        endcase

        roll = $urandom_range(99);
        if (roll < w_ins)
            item.func = FUNC_INSERT;
        else if (roll < w_ins + w_ups)
            item.func = FUNC_UPSERT;
        else if (roll < w_ins + w_ups + w_upd)
            item.func = FUNC_UPDATE;
        else if (roll < w_ins + w_ups + w_upd + w_rem)
            item.func = FUNC_REMOVE;
        else if (roll < w_ins + w_ups + w_upd + w_rem + w_look)
            item.func = FUNC_LOOKUP;
        else
            item.func = 3'($urandom_range(5, 7));  // unused codes, no-op

        if ($urandom_range(99) < 85)
            item.key = key_pool[$urandom_range(POOL_KEYS - 1)];
        else
            item.key = $urandom;
        item.value = $urandom;
        return item;
    endfunction

    task automatic run_random(input int count);
        traffic_mix_t mix;

        mix = MIX_FILL;
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && i % MIX_BLOCK == 0)
                mix = traffic_mix_t'($urandom_range(2));
            send_request(make_request(mix));
        end
    endtask

    // Directed opening: empty-table misses, extreme keys and values, duplicate
    // insert, upsert on a present and an absent key, slot reuse after remove,
    // and the unused function codes.
    task automatic run_directed();
        send_op(FUNC_LOOKUP, '0, '1);
        send_op(FUNC_REMOVE, '0, '0);
        send_op(FUNC_UPDATE, '0, '1);
        send_op(FUNC_INSERT, '0, '1);
        send_op(FUNC_INSERT, '1, '0);
        send_op(FUNC_INSERT, '0, 32'h1234_5678);   // duplicate
        send_op(FUNC_LOOKUP, '0, '0);
        send_op(FUNC_UPSERT, '1, 32'h5A5A_5A5A);   // present: overwrite
        send_op(FUNC_UPSERT, 32'h1234_5678, '1);   // absent: insert
        send_op(FUNC_UPDATE, '0, 32'hA5A5_A5A5);
        send_op(FUNC_LOOKUP, '1, '1);
        send_op(FUNC_REMOVE, '0, '0);
        send_op(FUNC_LOOKUP, '0, '0);
        send_op(3'd5, '0, '1);
        send_op(3'd6, '1, '1);
        send_op(3'd7, 32'h1234_5678, '0);
        send_op(FUNC_INSERT, 32'h8000_0001, 32'h7FFF_FFFE);  // takes the freed slot 0
        send_op(FUNC_LOOKUP, 32'h8000_0001, '0);
        send_op(FUNC_LOOKUP, 32'h1234_5678, '0);
    endtask

    // ------------------------------------------------------------------------
    // Response side: check each transfer, then pick the next stall value.
    // A pending hold-off keeps stall high until it has counted down.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (rsp_holdoff > 0)
            begin
                rsp_holdoff--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transfer on either side restarts the count.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;

        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        rsp_holdoff   = 0;
        sb            = new();

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender mostly busy, receiver mostly stalled
        send_idle_pct = 10;
        rsp_idle_pct  = 87;
        run_directed();
        run_random(510);

        // Phase 2: sender mostly idle, receiver mostly ready
        send_idle_pct = 87;
        rsp_idle_pct  = 10;
        run_random(510);

        // Phase 3: no idling; opens with a long response hold-off so the
        // response register and the request path both back up
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        rsp_holdoff   = HOLDOFF_CYCLES;
        run_random(510);

        req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
